[src/stcl_pkg.sv]
// shared constants, types and pattern tables for the serial text command led controller
package stcl_pkg;

    // line buffer depth in characters, one slot reserved for the terminator
    localparam int LINE_CHARS = 64;
    localparam int LEN_W      = $clog2(LINE_CHARS);

    typedef logic [LEN_W-1:0] len_t;

    // command patterns, one match flag each
    localparam int PAT_COUNT        = 5;
    localparam int PAT_LED_ON       = 0;
    localparam int PAT_LED_OFF      = 1;
    localparam int PAT_PING         = 2;
    localparam int PAT_BLINK_PREFIX = 3;
    localparam int PAT_BLINK_OFF    = 4;
    localparam int PREFIX_LEN       = 6;
    localparam int PAT_MAX_LEN      = 9;

    typedef logic [PAT_COUNT-1:0] flags_t;

    // item kinds on the request side
    typedef enum logic {
        CMD_BYTE = 1'b0,
        CMD_TICK = 1'b1
    } cmd_t;

    // response codes
    typedef enum logic [2:0] {
        RESP_NONE        = 3'd0,
        RESP_LED_ON      = 3'd1,
        RESP_LED_OFF     = 3'd2,
        RESP_PING        = 3'd3,
        RESP_BLINK_START = 3'd4,
        RESP_BLINK_END   = 3'd5,
        RESP_INVALID     = 3'd6,
        RESP_UNKNOWN     = 3'd7
    } resp_t;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [15:0] NUM_MAX   = 16'hFFFF;

    // pattern text, left aligned in nine character slots
    function automatic logic [8*PAT_MAX_LEN-1:0] pat_text(input int k);
        logic [8*PAT_MAX_LEN-1:0] txt;
        begin
            unique case (k)
                PAT_LED_ON:       txt = "LED on   ";
                PAT_LED_OFF:      txt = "LED off  ";
                PAT_PING:         txt = "PING     ";
                PAT_BLINK_PREFIX: txt = "BLINK    ";
                default:          txt = "BLINK off";
            endcase
            return txt;
        end
    endfunction

    // pattern length in characters
    function automatic logic [3:0] pat_len(input int k);
        logic [3:0] len;
        begin
            unique case (k)
                PAT_LED_ON:       len = 4'd6;
                PAT_LED_OFF:      len = 4'd7;
                PAT_PING:         len = 4'd4;
                PAT_BLINK_PREFIX: len = 4'd6;
                default:          len = 4'd9;
            endcase
            return len;
        end
    endfunction

    // character of pattern k at position p, zero past the slot
    function automatic logic [7:0] pat_char(input int k, input logic [3:0] p);
        logic [8*PAT_MAX_LEN-1:0] txt;
        logic [3:0]               slot;
        begin
            txt  = pat_text(k);
            slot = 4'(PAT_MAX_LEN - 1) - p;
            if (p >= 4'(PAT_MAX_LEN))
            begin
                return 8'h00;
            end
            return txt[8*slot +: 8];
        end
    endfunction

endpackage

[src/serial_text_command_led_controller_core.sv]
// serial text command led controller: request register, single pass decode, result register
//
// Request channel (s_axis): tuser carries the kind of item, 0 for a received text byte and
// 1 for a one millisecond tick; tdata carries the byte, ignored on ticks.
// Result channel (m_axis): exactly one result per request, tdata[2:0] the response code
// (none, led on, led off, ping, blink start, blink end, invalid, unknown) and tdata[3]
// the LED level after that request.
// Bytes are matched against the command words as they arrive; a CR or LF ends the line.
// An accepted request waits in the request register, which feeds the decode and state
// update; their outcome is registered in the result register once that register is free.
// Throughput is one request per cycle while the receiver takes results, set by the single
// pass of decode logic between the two registers; the request register refills in the
// same cycle the result moves on.
// When the receiver stalls, the result register holds, the request register holds one
// more item, and s_axis_tready then drops until the result is taken.
// Reset clears both stages, the line match state (all patterns matching, empty line),
// the LED, and the blink timer.
module serial_text_command_led_controller_core
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
    input  logic [0:0] s_axis_tuser,   // [0] command
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [2:0] response, [3] led_level, [7:4] zero
);

    // request register
    logic                 in_valid_reg, in_valid_next;
    stcl_pkg::cmd_t       in_cmd_reg;
    logic [7:0]           in_byte_reg;

    // result register
    logic                 out_valid_reg, out_valid_next;
    stcl_pkg::resp_t      out_resp_reg, out_resp_next;
    logic                 out_led_reg, out_led_next;

    // line and blink state
    stcl_pkg::len_t       line_length_reg, line_length_next;
    stcl_pkg::flags_t     match_flags_reg, match_flags_next;
    logic [15:0]          number_value_reg, number_value_next;
    logic                 number_valid_reg, number_valid_next;
    logic                 led_state_reg, led_state_next;
    logic                 blink_enabled_reg, blink_enabled_next;
    logic [15:0]          blink_interval_reg, blink_interval_next;
    logic [15:0]          elapsed_ticks_reg, elapsed_ticks_next;

    logic                 out_ready;
    logic                 process;
    logic                 in_take;

    // decode helpers
    logic                 is_term;
    logic                 is_digit;
    logic [19:0]          num_sum;
    logic [15:0]          elapsed_inc;
    logic [15:0]          num_eff;
    stcl_pkg::flags_t     exact;

    // handshakes
    assign out_ready     = !out_valid_reg || m_axis_tready;
    assign process       = in_valid_reg && out_ready;
    assign s_axis_tready = !in_valid_reg || out_ready;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_led_reg, out_resp_reg};

    // character classes and number accumulation
    assign is_term  = (in_byte_reg == stcl_pkg::CHAR_CR) || (in_byte_reg == stcl_pkg::CHAR_LF);
    assign is_digit = (in_byte_reg >= stcl_pkg::CHAR_ZERO) && (in_byte_reg <= stcl_pkg::CHAR_NINE);
    assign num_sum  = {4'b0000, number_value_reg} * 20'd10
                    + {12'd0, in_byte_reg - stcl_pkg::CHAR_ZERO};
    assign elapsed_inc = (elapsed_ticks_reg == stcl_pkg::NUM_MAX)
                       ? elapsed_ticks_reg : elapsed_ticks_reg + 16'd1;
    assign num_eff  = number_valid_reg ? number_value_reg : 16'd0;

    // exact pattern hits at the end of the line
    always_comb
    begin
        for (int k = 0; k < stcl_pkg::PAT_COUNT; k++)
        begin
            exact[k] = match_flags_reg[k]
                    && (line_length_reg == stcl_pkg::LEN_W'(stcl_pkg::pat_len(k)));
        end
    end

    // pipeline control
    always_comb
    begin
        in_valid_next  = in_take ? 1'b1 : (process ? 1'b0 : in_valid_reg);
        out_valid_next = process ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);
    end

    // decode and state update
    always_comb
    begin
        line_length_next    = line_length_reg;
        match_flags_next    = match_flags_reg;
        number_value_next   = number_value_reg;
        number_valid_next   = number_valid_reg;
        led_state_next      = led_state_reg;
        blink_enabled_next  = blink_enabled_reg;
        blink_interval_next = blink_interval_reg;
        elapsed_ticks_next  = elapsed_ticks_reg;
        out_resp_next       = stcl_pkg::RESP_NONE;

        if (process)
        begin
            if (in_cmd_reg == stcl_pkg::CMD_TICK)
            begin
                // blink timer
                if (blink_enabled_reg)
                begin
                    if (elapsed_inc >= blink_interval_reg)
                    begin
                        led_state_next     = !led_state_reg;
                        elapsed_ticks_next = 16'd0;
                    end
                    else
                    begin
                        elapsed_ticks_next = elapsed_inc;
                    end
                end
            end
            else if (is_term)
            begin
                // classify the line
                priority if (exact[stcl_pkg::PAT_LED_ON])
                begin
                    led_state_next = 1'b1;
                    out_resp_next  = stcl_pkg::RESP_LED_ON;
                end
                else if (exact[stcl_pkg::PAT_LED_OFF])
                begin
                    led_state_next = 1'b0;
                    out_resp_next  = stcl_pkg::RESP_LED_OFF;
                end
                else if (exact[stcl_pkg::PAT_PING])
                begin
                    out_resp_next = stcl_pkg::RESP_PING;
                end
                else if (match_flags_reg[stcl_pkg::PAT_BLINK_PREFIX]
                         && (line_length_reg >= stcl_pkg::LEN_W'(stcl_pkg::PREFIX_LEN)))
                begin
                    priority if (num_eff != 16'd0)
                    begin
                        blink_interval_next = num_eff;
                        blink_enabled_next  = 1'b1;
                        elapsed_ticks_next  = 16'd0;
                        out_resp_next       = stcl_pkg::RESP_BLINK_START;
                    end
                    else if (exact[stcl_pkg::PAT_BLINK_OFF])
                    begin
                        blink_enabled_next = 1'b0;
                        led_state_next     = 1'b0;
                        out_resp_next      = stcl_pkg::RESP_BLINK_END;
                    end
                    else
                    begin
                        out_resp_next = stcl_pkg::RESP_INVALID;
                    end
                end
                else
                begin
                    out_resp_next = stcl_pkg::RESP_UNKNOWN;
                end
                line_length_next  = '0;
                match_flags_next  = '1;
                number_value_next = 16'd0;
                number_valid_next = 1'b1;
            end
            else if (line_length_reg < stcl_pkg::LEN_W'(stcl_pkg::LINE_CHARS - 1))
            begin
                // incremental match of one character
                for (int k = 0; k < stcl_pkg::PAT_COUNT; k++)
                begin
                    if (line_length_reg < stcl_pkg::LEN_W'(stcl_pkg::pat_len(k)))
                    begin
                        if (stcl_pkg::pat_char(k, line_length_reg[3:0]) != in_byte_reg)
                        begin
                            match_flags_next[k] = 1'b0;
                        end
                    end
                    else if (k != stcl_pkg::PAT_BLINK_PREFIX)
                    begin
                        match_flags_next[k] = 1'b0;
                    end
                end
                if (line_length_reg >= stcl_pkg::LEN_W'(stcl_pkg::PREFIX_LEN))
                begin
                    if (is_digit)
                    begin
                        number_value_next = (num_sum > 20'(stcl_pkg::NUM_MAX))
                                          ? stcl_pkg::NUM_MAX : num_sum[15:0];
                    end
                    else
                    begin
                        number_valid_next = 1'b0;
                    end
                end
                line_length_next = line_length_reg + stcl_pkg::LEN_W'(1);
            end
        end
        out_led_next = led_state_next;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            line_length_reg    <= '0;
            match_flags_reg    <= '1;
            number_value_reg   <= 16'd0;
            number_valid_reg   <= 1'b1;
            led_state_reg      <= 1'b0;
            blink_enabled_reg  <= 1'b0;
            blink_interval_reg <= 16'd0;
            elapsed_ticks_reg  <= 16'd0;
        end
        else
        begin
            in_valid_reg       <= in_valid_next;
            out_valid_reg      <= out_valid_next;
            line_length_reg    <= line_length_next;
            match_flags_reg    <= match_flags_next;
            number_value_reg   <= number_value_next;
            number_valid_reg   <= number_valid_next;
            led_state_reg      <= led_state_next;
            blink_enabled_reg  <= blink_enabled_next;
            blink_interval_reg <= blink_interval_next;
            elapsed_ticks_reg  <= elapsed_ticks_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_cmd_reg  <= stcl_pkg::cmd_t'(s_axis_tuser[0]);
            in_byte_reg <= s_axis_tdata;
        end
        if (process)
        begin
            out_resp_reg <= out_resp_next;
            out_led_reg  <= out_led_next;
        end
    end

    // checks
    a_led_on_level: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_resp_reg == stcl_pkg::RESP_LED_ON) |-> out_led_reg)
        else $error("led on result with led low");

    a_led_off_level: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_resp_reg == stcl_pkg::RESP_LED_OFF
                           || out_resp_reg == stcl_pkg::RESP_BLINK_END)) |-> !out_led_reg)
        else $error("led off result with led high");

    a_tick_no_resp: assert property (@(posedge clk) disable iff (!rst_n)
        (process && in_cmd_reg == stcl_pkg::CMD_TICK) |=> (out_resp_reg == stcl_pkg::RESP_NONE))
        else $error("tick produced a response");

    a_line_bound: assert property (@(posedge clk) disable iff (!rst_n)
        line_length_reg <= stcl_pkg::LEN_W'(stcl_pkg::LINE_CHARS - 1))
        else $error("line length beyond buffer");

    a_blink_interval: assert property (@(posedge clk) disable iff (!rst_n)
        blink_enabled_reg |-> (blink_interval_reg != 16'd0))
        else $error("blinking with zero interval");

endmodule
